>>> design/set_difference_filter_macros.svh
// assertion macros for the set difference filter
// no dependencies; included by set_difference_filter, which checks its own logic
`ifndef SET_DIFFERENCE_FILTER_MACROS_SVH
`define SET_DIFFERENCE_FILTER_MACROS_SVH

// same-cycle implication
`define SDF_ASSERT_HOLDS(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("set difference filter check failed");

// next-cycle implication
`define SDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("set difference filter check failed");

`endif

>>> design/sdf_pkg.sv
// shared types, codes and constants of the set difference filter
// no dependencies; used by sdf_table and set_difference_filter
`default_nettype none

package sdf_pkg;

   localparam int DEF_TABLE_DEPTH = 64;
   localparam int DEF_VALUE_WIDTH = 32;

   localparam int FUNC_W     = 2;
   localparam int DATA_W     = 32;
   localparam int CNT_W      = 16;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_PAD_W  = RSP_DATA_W - (1 + DATA_W + CNT_W + CNT_W);

   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FILTER = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   // table port controls
   typedef struct packed {
      logic wr;
      logic rd;
   } tbl_ctl_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + CNT_W'(1);
   endfunction

endpackage

`default_nettype wire

>>> design/sdf_table.sv
// exclusion table: single-port synchronous memory with a registered read port
// depends on sdf_pkg for the port control struct
`default_nettype none

module sdf_table
   import sdf_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
   parameter int AW          = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
   input  wire logic                   clock,
   input  wire tbl_ctl_type            ctl,
   input  wire logic [AW-1:0]          addr,
   input  wire logic [VALUE_WIDTH-1:0] wr_data,
   output logic      [VALUE_WIDTH-1:0] rd_data
);

   logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr) begin
         mem[addr] <= wr_data;
      end
      if (ctl.rd) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/set_difference_filter.sv
// Set difference filter. Append words (tuser = 0) load the exclusion table, filter words
// (tuser = 1) are checked against the stored entries and come back marked kept, with their
// position in the filtered run, or removed, with the running removed count; tlast on a
// filter word closes the run and zeroes both run counters. Clear words (tuser = 2) empty
// the table and give no result; code 3 is ignored. One word is in flight at a time. An
// append goes from accept to S_PUT; a filter goes through S_SCAN (S_MISS on an empty
// table) to S_PUT, and its scan stops early on a match. The scan of the single-port
// table compares one entry per cycle, and S_PUT waits while the output register is full.
// A finished result sits in the output register while the next word is taken. No clearing pass is needed after reset.
`default_nettype none
`include "set_difference_filter_macros.svh"

module set_difference_filter
   import sdf_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [DATA_W-1:0]     req_tdata,  // [31:0] value
   input  wire logic [FUNC_W-1:0]     req_tuser,  // [1:0] func
   input  wire logic                  req_tlast,  // last_item
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,  // [0] kept, [32:1] kept_value,
                                                  // [48:33] kept_position,
                                                  // [64:49] removed_count, rest zero
   output logic                       rsp_tuser,  // table_full
   output logic                       rsp_tlast   // run_end
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_MISS, S_PUT} state_type;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [AW-1:0]             idx_ff, idx_in;
   logic [CNT_W-1:0]          kept_ff, kept_in;
   logic [CNT_W-1:0]          removed_ff, removed_in;
   logic signed [DATA_W-1:0]  val_ff, val_in;
   logic                      last_ff, last_in;
   logic [RSP_DATA_W-1:0]     pend_data_ff, pend_data_in;
   logic                      pend_user_ff, pend_user_in;
   logic                      pend_last_ff, pend_last_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                      rsp_user_ff, rsp_user_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   tbl_ctl_type               tbl_ctl;
   logic [AW-1:0]             tbl_addr;
   logic [VALUE_WIDTH-1:0]    tbl_rd_data;
   logic [VALUE_WIDTH-1:0]    tbl_wr_data;

   logic                      req_acc;
   logic signed [DATA_W-1:0]  req_value;
   logic                      hit;
   logic                      at_end;
   logic                      fin;
   logic                      scan_start;
   logic [CNT_W-1:0]          rem_new;
   logic [CNT_W-1:0]          kept_new;

   sdf_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .AW          (AW)
   ) u_table (
      .clock   (clock),
      .ctl     (tbl_ctl),
      .addr    (tbl_addr),
      .wr_data (tbl_wr_data),
      .rd_data (tbl_rd_data)
   );

   assign req_tready  = (state_ff == S_IDLE);
   assign req_acc     = req_tvalid && req_tready;
   assign req_value   = req_tdata;
   // compares use the low VALUE_WIDTH bits, zero-extended when wider
   assign tbl_wr_data = VALUE_WIDTH'($unsigned(req_value));

   assign hit    = (state_ff == S_SCAN) && (tbl_rd_data == VALUE_WIDTH'($unsigned(val_ff)));
   assign at_end = (CW'(idx_ff) + CW'(1)) == count_ff;
   assign fin    = ((state_ff == S_SCAN) && (hit || at_end)) || (state_ff == S_MISS);

   assign scan_start = req_acc && (req_tuser == FUNC_FILTER) && (count_ff != '0);

   assign rem_new  = hit ? sat_inc(removed_ff) : removed_ff;
   assign kept_new = hit ? kept_ff : sat_inc(kept_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      kept_in      = kept_ff;
      removed_in   = removed_ff;
      val_in       = val_ff;
      last_in      = last_ff;
      pend_data_in = pend_data_ff;
      pend_user_in = pend_user_ff;
      pend_last_in = pend_last_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      tbl_ctl      = '0;
      tbl_addr     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               unique case (req_tuser)
                  FUNC_APPEND: begin
                     pend_data_in = '0;
                     pend_last_in = 1'b0;
                     if (count_ff < CW'(TABLE_DEPTH)) begin
                        tbl_ctl.wr   = 1'b1;
                        tbl_addr     = count_ff[AW-1:0];
                        count_in     = count_ff + CW'(1);
                        pend_user_in = 1'b0;
                     end else begin
                        pend_user_in = 1'b1;
                     end
                     state_in = S_PUT;
                  end
                  FUNC_FILTER: begin
                     val_in  = req_value;
                     last_in = req_tlast;
                     idx_in  = '0;
                     if (count_ff == '0) begin
                        state_in = S_MISS;
                     end else begin
                        tbl_ctl.rd = 1'b1;
                        state_in   = S_SCAN;
                     end
                  end
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN, S_MISS: begin
            if (fin) begin
               pend_data_in = {RSP_PAD_W'(0), rem_new, (hit ? CNT_W'(0) : kept_ff),
                               val_ff, !hit};
               pend_user_in = 1'b0;
               pend_last_in = last_ff;
               kept_in      = last_ff ? '0 : kept_new;
               removed_in   = last_ff ? '0 : rem_new;
               state_in     = S_PUT;
            end else begin
               // fetch the next entry while this one was compared
               idx_in     = idx_ff + AW'(1);
               tbl_ctl.rd = 1'b1;
               tbl_addr   = idx_ff + AW'(1);
            end
         end
         S_PUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_data_in  = pend_data_ff;
               rsp_user_in  = pend_user_ff;
               rsp_last_in  = pend_last_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         kept_ff      <= '0;
         removed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         kept_ff      <= kept_in;
         removed_ff   <= removed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      last_ff      <= last_in;
      pend_data_ff <= pend_data_in;
      pend_user_ff <= pend_user_in;
      pend_last_ff <= pend_last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_user_ff  <= rsp_user_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

   `SDF_ASSERT_HOLDS(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(TABLE_DEPTH))
   `SDF_ASSERT_HOLDS(a_scan_in_range, clock, reset, state_ff == S_SCAN, CW'(idx_ff) < count_ff)
   `SDF_ASSERT_NEXT(a_filter_scans, clock, reset, scan_start, state_ff == S_SCAN)
   `SDF_ASSERT_HOLDS(a_rsp_from_put, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == S_PUT)

endmodule

`default_nettype wire

>>> dv/set_difference_filter_checker.sv
`timescale 1ns / 1ps
// result checker for the set difference filter: keeps its own exclusion table and run
// counters, predicts the result word of every accepted append and filter word and compares field by field
// depends on sdf_pkg for widths and function codes
module set_difference_filter_checker
   import sdf_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [DATA_W-1:0]     req_tdata,
   input  logic [FUNC_W-1:0]     req_tuser,
   input  logic                  req_tlast,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  rsp_tuser,
   input  logic                  rsp_tlast,
   output int                    mismatch_count,
   output int                    outstanding
);

   typedef struct packed {
      logic              kept;
      logic [DATA_W-1:0] value;
      logic [CNT_W-1:0]  position;
      logic [CNT_W-1:0]  removed;
      logic              run_end;
      logic              table_full;
   } filter_outcome_type;

   // only the low VALUE_WIDTH bits take part in compares
   localparam logic [DATA_W-1:0] CMP_MASK =
      (VALUE_WIDTH >= DATA_W) ? {DATA_W{1'b1}} : ((DATA_W'(1) << VALUE_WIDTH) - DATA_W'(1));

   // result word layout
   localparam int POS_LSB = 1 + DATA_W;
   localparam int REM_LSB = POS_LSB + CNT_W;
   localparam int PAD_LSB = REM_LSB + CNT_W;

   logic [DATA_W-1:0]  excl_table [TABLE_DEPTH];
   int                 entries;
   logic [CNT_W-1:0]   kept_run;
   logic [CNT_W-1:0]   removed_run;
   filter_outcome_type awaited_outcomes [$];

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
   end

   task automatic compute_filter_outcome(input logic [FUNC_W-1:0] func,
                                         input logic [DATA_W-1:0] value,
                                         input logic              last);
      filter_outcome_type o;
      logic               hit;
      o   = '0;
      hit = 1'b0;
      case (func)
         FUNC_APPEND: begin
            if (entries < TABLE_DEPTH) begin
               excl_table[entries] = value & CMP_MASK;
               entries++;
            end else begin
               o.table_full = 1'b1;
            end
            awaited_outcomes.push_back(o);
         end
         FUNC_FILTER: begin
            for (int i = 0; i < entries; i++)
               if (excl_table[i] == (value & CMP_MASK)) hit = 1'b1;
            o.value = value;
            if (hit) begin
               if (removed_run != CNT_MAX) removed_run = removed_run + 1'b1;
            end else begin
               o.kept     = 1'b1;
               o.position = kept_run;
               if (kept_run != CNT_MAX) kept_run = kept_run + 1'b1;
            end
            o.removed = removed_run;
            o.run_end = last;
            if (last) begin
               kept_run    = '0;
               removed_run = '0;
            end
            awaited_outcomes.push_back(o);
         end
         FUNC_CLEAR: begin
            // run counters survive a clear
            entries = 0;
         end
         default: ;
      endcase
   endtask

   task automatic compare_field(input string label, input logic [63:0] want,
                                input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_result_word();
      filter_outcome_type want;
      if (awaited_outcomes.size() == 0) begin
         $display("%0t: result word with nothing pending, expected none actual %h/%b/%b",
                  $time, rsp_tdata, rsp_tuser, rsp_tlast);
         mismatch_count++;
      end else begin
         want = awaited_outcomes.pop_front();
         compare_field("kept", want.kept, rsp_tdata[0]);
         compare_field("kept_value", want.value, rsp_tdata[1 +: DATA_W]);
         compare_field("kept_position", want.position, rsp_tdata[POS_LSB +: CNT_W]);
         compare_field("removed_count", want.removed, rsp_tdata[REM_LSB +: CNT_W]);
         compare_field("tdata padding", '0, rsp_tdata[PAD_LSB +: RSP_PAD_W]);
         compare_field("run_end", want.run_end, rsp_tlast);
         compare_field("table_full", want.table_full, rsp_tuser);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         entries     = 0;
         kept_run    = '0;
         removed_run = '0;
         awaited_outcomes.delete();
      end else begin
         // a result leaving on the same edge belongs to the previous word
         if (rsp_tvalid && rsp_tready) check_result_word();
         if (req_tvalid && req_tready) compute_filter_outcome(req_tuser, req_tdata, req_tlast);
      end
      outstanding <= awaited_outcomes.size();
   end

endmodule

>>> dv/set_difference_filter_test.sv
`timescale 1ns / 1ps
// top of the set difference filter testbench: clock, reset, stimulus words and verdict
// depends on sdf_pkg, set_difference_filter and set_difference_filter_checker
module set_difference_filter_test;
   import sdf_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam int TOTAL_WORDS    = 610;
   localparam int STALL_PCT      = 18;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 80;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata  = '0;
   logic [FUNC_W-1:0]     req_tuser  = FUNC_APPEND;
   logic                  req_tlast  = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;
   int                    mismatch_count;
   int                    outstanding;

   int                    words_sent  = 0;
   int                    idle_cycles = 0;
   logic                  steady      = 1'b0;
   logic [DATA_W-1:0]     loaded [$];

   set_difference_filter i_dut (.*);

   set_difference_filter_checker i_checker (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= steady || ($urandom_range(99) >= STALL_PCT);
   end

   // ends the run when neither channel moves a word for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_word(input logic [FUNC_W-1:0] func, input logic [DATA_W-1:0] value,
                            input logic last);
      if (!steady)
         while ($urandom_range(99) < STALL_PCT) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (func != FUNC_UNUSED) words_sent++;
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic load_entry(input logic [DATA_W-1:0] value);
      send_word(FUNC_APPEND, value, 1'($urandom_range(1)));
      if (loaded.size() < DEF_TABLE_DEPTH) loaded.push_back(value);
   endtask

   task automatic clear_table();
      send_word(FUNC_CLEAR, $urandom, 1'($urandom_range(1)));
      loaded.delete();
   endtask

   // half stored values, some one bit away from a stored value, some extremes, the rest random
   function automatic logic [DATA_W-1:0] pick_value();
      logic [DATA_W-1:0] v;
      v = $urandom;
      case ($urandom_range(9))
         0, 1, 2, 3, 4: begin
            if (loaded.size() != 0) v = loaded[$urandom_range(loaded.size() - 1)];
         end
         5: begin
            if (loaded.size() != 0)
               v = loaded[$urandom_range(loaded.size() - 1)]
                   ^ (DATA_W'(1) << $urandom_range(DATA_W - 1));
         end
         6: begin
            case ($urandom_range(3))
               0: v = '0;
               1: v = '1;
               2: v = {1'b0, {(DATA_W - 1){1'b1}}};
               default: v = {1'b1, {(DATA_W - 1){1'b0}}};
            endcase
         end
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      int                n_load;
      int                run_len;
      logic [FUNC_W-1:0] f;
      logic [DATA_W-1:0] v;

      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty table keeps everything
      send_word(FUNC_FILTER, 32'h0000_0000, 1'b0);
      send_word(FUNC_FILTER, 32'h7FFF_FFFF, 1'b0);
      send_word(FUNC_FILTER, 32'h8000_0000, 1'b0);
      send_word(FUNC_FILTER, 32'hFFFF_FFFF, 1'b1);
      send_word(FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1);
      send_word(FUNC_APPEND, 32'h8000_0000, 1'b1);
      loaded.push_back(32'h8000_0000);
      load_entry(32'h7FFF_FFFF);
      load_entry(32'h0000_0000);
      load_entry(32'hFFFF_FFFF);
      send_word(FUNC_FILTER, 32'h8000_0000, 1'b0);
      send_word(FUNC_FILTER, 32'h8000_0001, 1'b0);
      send_word(FUNC_FILTER, 32'hFFFF_FFFF, 1'b0);
      send_word(FUNC_FILTER, 32'h0000_0000, 1'b1);
      send_word(FUNC_CLEAR, 32'h0000_0000, 1'b1);
      loaded.delete();
      send_word(FUNC_FILTER, 32'h8000_0000, 1'b1);
      load_entry(32'h5555_5555);
      load_entry(32'hAAAA_AAAA);
      send_word(FUNC_FILTER, 32'hAAAA_AAAA, 1'b0);
      send_word(FUNC_FILTER, 32'h5555_5554, 1'b1);

      for (int episode = 0; words_sent < TOTAL_WORDS; episode++) begin
         steady <= (words_sent >= 300) && (words_sent < 420);
         if (episode == 0 || $urandom_range(19) == 0) drain_results();
         if ($urandom_range(9) < 8) begin
            // well-formed: optional clear, table load, then one filtered run
            if (episode == 0 || $urandom_range(2) != 0) clear_table();
            n_load = (episode == 0 || $urandom_range(9) == 0) ? $urandom_range(60, 70)
                                                              : $urandom_range(0, 8);
            repeat (n_load) load_entry(pick_value());
            run_len = $urandom_range(1, 16);
            for (int i = 0; i < run_len; i++)
               send_word(FUNC_FILTER, pick_value(), i == run_len - 1);
         end else begin
            repeat ($urandom_range(1, 6)) begin
               f = FUNC_W'($urandom_range(3));
               v = pick_value();
               send_word(f, v, 1'($urandom_range(1)));
               if (f == FUNC_APPEND && loaded.size() < DEF_TABLE_DEPTH) loaded.push_back(v);
               if (f == FUNC_CLEAR) loaded.delete();
            end
         end
      end
      steady <= 1'b0;

      drain_results();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
